/* hw/rtl/min_cost_route_dp_core_defines.svh */
// Assertion macros shared by the min-cost route core RTL.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef MIN_COST_ROUTE_DP_CORE_DEFINES_SVH
`define MIN_COST_ROUTE_DP_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mcr_pkg.sv */
// Types and constants for the min-cost route core.
// No dependencies.
`timescale 1ns / 1ps

package mcr_pkg;

   localparam int COST_W = 22;
   localparam int IN_W   = 17;
   localparam int CFG_W  = 7;
   localparam int NUM_POSTS_RESET = 4;

   localparam logic [COST_W-1:0] COST_ALL_ONES = '1;

   // Per-entry control carried from the index stage to the relax stage.
   typedef struct packed {
      logic            relax;  // upper triangle, positive cost
      logic            first;  // column 0: latch row base
      logic            last;   // final entry of the table
      logic [IN_W-2:0] cost;   // magnitude of a positive cost
   } entry_ctl_type;

endpackage

/* hw/rtl/mcr_best_mem.sv */
// Best-cost memory: one write port, one registered read port, per-entry valid bits.
// Depends on mcr_pkg. Unwritten entries read as the table start value.
`timescale 1ns / 1ps

module mcr_best_mem #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [mcr_pkg::COST_W-1:0]   wr_data,
   output logic [mcr_pkg::COST_W-1:0]   rd_data
);
   import mcr_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [COST_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  vld_ff;
   logic [COST_W-1:0] rd_raw_ff;
   logic              rd_hit_ff;
   logic              rd_zero_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff  <= mem[rd_addr];
         rd_zero_ff <= (rd_addr == AW'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (rd_en) begin
            rd_hit_ff <= vld_ff[rd_addr];
         end
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (clear) begin
            vld_ff <= '0;
         end
      end
   end

   // Start value: post 0 at zero, the rest unreached.
   assign rd_data = rd_hit_ff  ? rd_raw_ff :
                    rd_zero_ff ? '0 : COST_ALL_ONES;

endmodule

/* hw/rtl/mcr_relax.sv */
// Relax stage: read-modify-write of one best-cost entry, write forwarding,
// row base latch and two-deep result registers. Depends on mcr_pkg.
`timescale 1ns / 1ps
`include "min_cost_route_dp_core_defines.svh"

module mcr_relax #(
   parameter int AW = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         s0_accept,
   input  logic [AW-1:0]                s0_addr,
   input  mcr_pkg::entry_ctl_type       s0_ctl,
   input  logic [mcr_pkg::COST_W-1:0]   rd_data,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [mcr_pkg::COST_W-1:0]   wr_data,
   output logic                         rsp_room,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mcr_pkg::COST_W-1:0]   rsp_min_cost,
   output logic                         rsp_reachable
);
   import mcr_pkg::*;

   logic              s1_vld_ff;
   logic [AW-1:0]     s1_addr_ff;
   entry_ctl_type     s1_ctl_ff;
   logic              s1_fwd_ff;
   logic              s1_fwd_in;
   logic [COST_W-1:0] fwd_data_ff;
   logic [COST_W-1:0] base_ff;
   logic [COST_W-1:0] old_cost;
   logic [COST_W:0]   sum;
   logic [COST_W-1:0] sat_sum;
   logic              rsp_valid_ff;
   logic [COST_W-1:0] rsp_cost_ff;
   logic              rsp_reach_ff;
   logic              spr_valid_ff;
   logic [COST_W-1:0] spr_cost_ff;
   logic              spr_reach_ff;
   logic              rsp_load;
   logic              rsp_pop;
   logic              head_free;
   logic              new_reach;

   // Memory read misses a write landing on the same edge; take it from here.
   assign old_cost = s1_fwd_ff ? fwd_data_ff : rd_data;
   assign sum      = {1'b0, base_ff} + {{(COST_W-IN_W+2){1'b0}}, s1_ctl_ff.cost};
   assign sat_sum  = sum[COST_W] ? COST_ALL_ONES : sum[COST_W-1:0];

   assign wr_en   = s1_vld_ff && s1_ctl_ff.relax && (base_ff != COST_ALL_ONES)
                    && (sat_sum < old_cost);
   assign wr_addr = s1_addr_ff;
   assign wr_data = sat_sum;

   assign s1_fwd_in = wr_en && (wr_addr == s0_addr);

   // Result queue: head drives the port, spare catches a result while head waits.
   assign rsp_load  = s1_vld_ff && s1_ctl_ff.last;
   assign rsp_pop   = rsp_valid_ff && rsp_ready;
   assign head_free = !rsp_valid_ff || rsp_pop;
   assign new_reach = (old_cost != COST_ALL_ONES);

   // Room for one more result in the result registers, counting the one in flight and any transfer on the port.
   assign rsp_room = spr_valid_ff ? (rsp_ready && !rsp_load)
                                  : (!rsp_valid_ff || !rsp_load || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         spr_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_accept;
         if (s0_accept) begin
            s1_fwd_ff <= s1_fwd_in;
         end
         if (head_free) begin
            rsp_valid_ff <= spr_valid_ff || rsp_load;
            spr_valid_ff <= spr_valid_ff && rsp_load;
         end else if (rsp_load) begin
            spr_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_accept) begin
         s1_addr_ff  <= s0_addr;
         s1_ctl_ff   <= s0_ctl;
         fwd_data_ff <= wr_data;
      end
      if (s1_vld_ff && s1_ctl_ff.first) begin
         base_ff <= old_cost;
      end
      if (head_free) begin
         if (spr_valid_ff) begin
            rsp_cost_ff  <= spr_cost_ff;
            rsp_reach_ff <= spr_reach_ff;
         end else if (rsp_load) begin
            rsp_cost_ff  <= old_cost;
            rsp_reach_ff <= new_reach;
         end
      end
      if (rsp_load && (spr_valid_ff || !head_free)) begin
         spr_cost_ff  <= old_cost;
         spr_reach_ff <= new_reach;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_cost  = rsp_cost_ff;
   assign rsp_reachable = rsp_reach_ff;

   `MCR_ASSERT_NXT(a_last_loads_rsp, clock, reset, s1_vld_ff && s1_ctl_ff.last, rsp_valid_ff, "final entry did not produce a result")
   `MCR_ASSERT_IMP(a_no_sat_write, clock, reset, wr_en, wr_data != COST_ALL_ONES, "saturated route written back")
   `MCR_ASSERT_IMP(a_wr_only_relax, clock, reset, wr_en, !s1_ctl_ff.first && !s1_ctl_ff.last, "write from a non-relaxing entry")
   `MCR_ASSERT_IMP(a_spare_no_overrun, clock, reset, spr_valid_ff, !rsp_load, "result arrived with both registers full")

endmodule

/* hw/rtl/min_cost_route_dp_core.sv */
// Min-cost route core: one cost-table entry accepted per cycle unless stalled, row-major order.
// Result path: the last entry passes the relax stage register, then lands in the head or spare result register.
// Throughput: one entry per cycle, set by the single read-modify-write of the best-cost memory;
// two result registers let one-post tables stream; a last entry stalls only while no result register is left for it.
// Reset (synchronous): num_posts = 4 (MAX_POSTS if smaller), indexes zero, best-cost valid bits cleared.
// Depends on mcr_pkg, mcr_best_mem, mcr_relax and the assertion macro header.
`timescale 1ns / 1ps
`include "min_cost_route_dp_core_defines.svh"

module min_cost_route_dp_core #(
   parameter int MAX_POSTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mcr_pkg::CFG_W-1:0]         csr_num_posts,
   // cost-table entries
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [mcr_pkg::IN_W-1:0]   req_cost,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mcr_pkg::COST_W-1:0]        rsp_min_cost,
   output logic                              rsp_reachable
);
   import mcr_pkg::*;

   localparam int AW = $clog2(MAX_POSTS);
   localparam int RESET_POSTS = (MAX_POSTS < NUM_POSTS_RESET) ? MAX_POSTS : NUM_POSTS_RESET;
   localparam logic [8:0] MAX_POSTS_W = 9'(MAX_POSTS);

   // Table position and the index of the last post (effective post count - 1).
   logic [AW-1:0] row_ff, row_in;
   logic [AW-1:0] col_ff, col_in;
   logic [AW-1:0] last_idx_ff, last_idx_in;

   logic          csr_accept;
   logic          req_accept;
   logic          col_last;
   logic          row_last;
   logic          entry_last;
   logic          rsp_room;
   logic          table_clear;
   logic [8:0]    csr_wide;
   logic [AW-1:0] rd_addr;
   entry_ctl_type ctl;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [COST_W-1:0] wr_data;
   logic [COST_W-1:0] rd_data;

   // The user must make writes land only while idle; the block does not enforce it and holds nothing off.
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // Clamp the post count: zero acts as one, above MAX_POSTS acts as MAX_POSTS.
   assign csr_wide = {2'b00, csr_num_posts};
   always_comb begin
      if (csr_wide == 9'd0) begin
         last_idx_in = '0;
      end else if (csr_wide > MAX_POSTS_W) begin
         last_idx_in = AW'(MAX_POSTS - 1);
      end else begin
         last_idx_in = AW'(csr_wide - 9'd1);
      end
   end

   assign col_last   = (col_ff == last_idx_ff);
   assign row_last   = (row_ff == last_idx_ff);
   assign entry_last = col_last && row_last;

   // A last entry goes in only when a result register will be free for its result.
   assign req_ready  = !entry_last || rsp_room;
   assign req_accept = req_valid && req_ready;

   // Row-major walk; the table restarts after its last entry.
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         last_idx_ff <= AW'(RESET_POSTS - 1);
      end else if (csr_accept) begin
         row_ff      <= '0;
         col_ff      <= '0;
         last_idx_ff <= last_idx_in;
      end else if (req_accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Column 0 fetches the row's own best (the row base); other columns fetch
   // the column's best for relaxation. Column 0 never relaxes, so one port suffices.
   assign rd_addr = (col_ff == '0) ? row_ff : col_ff;

   assign ctl.relax = (row_ff < col_ff) && !req_cost[IN_W-1] && (req_cost != '0);
   assign ctl.first = (col_ff == '0);
   assign ctl.last  = entry_last;
   assign ctl.cost  = req_cost[IN_W-2:0];

   // New table: drop every stored best. The entry before a last entry never writes.
   assign table_clear = csr_accept || (req_accept && entry_last);

   mcr_best_mem #(
      .DEPTH   (MAX_POSTS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (table_clear),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   mcr_relax #(
      .AW            (AW)
   ) u_relax (
      .clock         (clock),
      .reset         (reset),
      .s0_accept     (req_accept),
      .s0_addr       (rd_addr),
      .s0_ctl        (ctl),
      .rd_data       (rd_data),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rsp_room      (rsp_room),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_min_cost  (rsp_min_cost),
      .rsp_reachable (rsp_reachable)
   );

   `MCR_ASSERT_NXT(a_wrap_after_last, clock, reset, req_accept && entry_last && !csr_accept, row_ff == '0 && col_ff == '0, "indexes did not wrap after the last entry")
   `MCR_ASSERT_NXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_min_cost), "result dropped before its transfer")
   `MCR_ASSERT_IMP(a_idx_in_range, clock, reset, 1'b1, row_ff <= last_idx_ff && col_ff <= last_idx_ff, "table index past the post count")

endmodule
